[rtl/core/esrf_pkg.sv]
// Shared widths, codes, types and divide helpers for the encoder speed runaway filter.
package esrf_pkg;

    localparam int COUNT_BITS = 16;
    localparam int SPD_W      = 17;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int ACC_W      = 32;
    localparam int MODE_W     = 2;

    localparam int RAW_W  = COUNT_BITS + 1;
    localparam int CALC_W = ((RAW_W > SPD_W) ? RAW_W : SPD_W) + 5;

    // Reciprocal of ten: exact for every magnitude below 2**CALC_W.
    localparam int DIV10_SH = CALC_W + 4;
    localparam int DIV10_MW = DIV10_SH - 3;
    localparam int PROD_W   = CALC_W + DIV10_MW;
    localparam logic [DIV10_MW-1:0] DIV10_M =
        DIV10_MW'(((64'd1 << DIV10_SH) / 64'd10) + 64'd1);

    localparam logic [CFG_W-1:0] SPEED_LIMIT_RST = CFG_W'(400);
    localparam logic [CFG_W-1:0] ACCEL_THR_RST   = CFG_W'(60);

    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_THR   = CFG_IDX_W'(1);

    localparam logic [MODE_W-1:0] MODE_INNER = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_OUTER = MODE_W'(2);

    typedef enum logic [1:0] {
        RUN_NONE  = 2'd0,
        RUN_ACCEL = 2'd1,
        RUN_OVER  = 2'd2
    } t_runaway;

    typedef struct packed {
        logic [CFG_W-1:0] speed_limit;
        logic [CFG_W-1:0] accel_threshold;
    } t_cfg;

    typedef logic signed [CALC_W-1:0] t_calc;

    // Signed divide by ten, truncating toward zero.
    function automatic t_calc sdiv10(input t_calc x);
        logic [CALC_W-1:0] mag;
        logic [PROD_W-1:0] prod;
        logic [CALC_W-1:0] q;
        mag  = x[CALC_W-1] ? CALC_W'(-x) : CALC_W'(x);
        prod = {{DIV10_MW{1'b0}}, mag} * {{CALC_W{1'b0}}, DIV10_M};
        q    = CALC_W'(prod[PROD_W-1:DIV10_SH]);
        return x[CALC_W-1] ? -$signed(q) : $signed(q);
    endfunction

    // Signed halving, truncating toward zero.
    function automatic t_calc sdiv2(input t_calc x);
        t_calc t;
        t = x + $signed({{(CALC_W-1){1'b0}}, x[CALC_W-1]});
        return t >>> 1;
    endfunction

    function automatic t_calc sext_spd(input logic signed [SPD_W-1:0] v);
        return $signed({{(CALC_W-SPD_W){v[SPD_W-1]}}, v});
    endfunction

    function automatic t_calc zext_cfg(input logic [CFG_W-1:0] v);
        return $signed({{(CALC_W-CFG_W){1'b0}}, v});
    endfunction

endpackage

[rtl/core/esrf_in_if.sv]
// Sample channel: encoder counts, direction pins and accumulate mode.
interface esrf_in_if;
    import esrf_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [COUNT_BITS-1:0] left_count;
    logic                  left_dir;
    logic [COUNT_BITS-1:0] right_count;
    logic                  right_dir;
    logic [MODE_W-1:0]     accum_mode;

    modport source (output valid, left_count, left_dir, right_count, right_dir, accum_mode,
                    input ready);
    modport sink   (input valid, left_count, left_dir, right_count, right_dir, accum_mode,
                    output ready);
endinterface

[rtl/core/esrf_out_if.sv]
// Result channel: filtered and fused speeds, runaway flags and distances.
interface esrf_out_if;
    import esrf_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [SPD_W-1:0] fused_speed;
    logic signed [SPD_W-1:0] left_filtered;
    logic signed [SPD_W-1:0] right_filtered;
    logic [1:0]              left_flag;
    logic [1:0]              right_flag;
    logic signed [ACC_W-1:0] inner_distance;
    logic signed [ACC_W-1:0] outer_distance;
    logic signed [ACC_W-1:0] total_distance;

    modport source (output valid, fused_speed, left_filtered, right_filtered, left_flag,
                    right_flag, inner_distance, outer_distance, total_distance,
                    input ready);
    modport sink   (input valid, fused_speed, left_filtered, right_filtered, left_flag,
                    right_flag, inner_distance, outer_distance, total_distance,
                    output ready);
endinterface

[rtl/core/esrf_wheel.sv]
// One wheel: signed speed, runaway flag update and adaptive low-pass filter.
module esrf_wheel (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_load,
    input  logic [esrf_pkg::COUNT_BITS-1:0]  i_count,
    input  logic                             i_neg,
    input  esrf_pkg::t_cfg                   i_cfg,
    output logic signed [esrf_pkg::SPD_W-1:0] o_filtered,
    output esrf_pkg::t_runaway               o_flag
);
    import esrf_pkg::*;

    logic signed [SPD_W-1:0] r_prev;
    logic signed [SPD_W-1:0] n_prev;
    t_runaway                r_flag;
    t_runaway                n_flag;

    t_calc cnt_ext, raw, prev_ext, rise, thr_ext, lim_ext, scaled, filt;
    logic  rise_gt;

    always_comb begin
        cnt_ext  = $signed({{(CALC_W-COUNT_BITS){1'b0}}, i_count});
        raw      = i_neg ? -cnt_ext : cnt_ext;
        prev_ext = sext_spd(r_prev);
        thr_ext  = zext_cfg(i_cfg.accel_threshold);
        lim_ext  = zext_cfg(i_cfg.speed_limit);
        rise     = raw - prev_ext;
        rise_gt  = rise > thr_ext;

        n_flag = r_flag;
        if (rise_gt) begin
            n_flag = RUN_ACCEL;
        end
        if (raw > lim_ext) begin
            n_flag = RUN_OVER;
        end
        // drop the flag once the wheel is back inside both bounds
        if (n_flag != RUN_NONE && !rise_gt && raw < lim_ext && raw > 0) begin
            n_flag = RUN_NONE;
        end

        scaled = (raw <<< 3) + raw + prev_ext;
        filt   = (n_flag == RUN_NONE) ? sdiv10(scaled) : sdiv2(raw + prev_ext);
        n_prev = filt[SPD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_flag <= RUN_NONE;
        end else if (i_load) begin
            r_prev <= n_prev;
            r_flag <= n_flag;
        end
    end

    assign o_filtered = r_prev;
    assign o_flag     = r_flag;

endmodule

[rtl/core/encoder_speed_runaway_filter.sv]
// Top level: encoder speed runaway filter, four-stage pipeline with config registers.
//
//   channel  | dir | handshake      | payload
//   ---------+-----+----------------+----------------------------------------------
//   i_in     | in  | valid / ready  | left/right count and dir, accum_mode
//   o_out    | out | valid / ready  | fused speed, filtered speeds, flags, distances
//   i_cfg_*  | in  | i_cfg_we only  | i_cfg_idx selects speed_limit or accel_threshold
//
// One beat per cycle sustained while o_out is ready; output valid rises once the beat reaches stage 4.
// Stages: input register, wheel filters, fusion with smoothing, distance accumulators.
// Each state recurrence closes inside its own stage, which sets the one-beat rate.
// Synchronous reset clears flags, filter history, accumulators and valid bits, and loads config defaults.
// A stalled output holds its beat; earlier stages keep filling until the pipe is full.
module encoder_speed_runaway_filter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    esrf_in_if.sink                         i_in,
    esrf_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [esrf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [esrf_pkg::CFG_W-1:0]      i_cfg_data
);
    import esrf_pkg::*;

    t_cfg r_cfg;

    // stage valid bits and load strobes
    logic r_v1, r_v2, r_v3, r_v4;
    logic ld1, ld2, ld3, ld4;

    // stage 1: input register
    logic [COUNT_BITS-1:0] r1_lcount, r1_rcount;
    logic                  r1_ldir, r1_rdir;
    logic [MODE_W-1:0]     r1_mode;

    // stage 2: wheel state doubles as stage data
    logic signed [SPD_W-1:0] w_lf, w_rf;
    t_runaway                w_lflag, w_rflag;
    logic [MODE_W-1:0]       r2_mode;

    // stage 3: fused speed state plus carried fields
    logic signed [SPD_W-1:0] r_fused;
    logic signed [SPD_W-1:0] n_fused;
    logic signed [SPD_W-1:0] r3_lf, r3_rf;
    t_runaway                r3_lflag, r3_rflag;
    logic [MODE_W-1:0]       r3_mode;

    // stage 4: output register and accumulators
    logic signed [SPD_W-1:0] r4_fused, r4_lf, r4_rf;
    t_runaway                r4_lflag, r4_rflag;
    logic signed [ACC_W-1:0] r_inner, r_outer, r_total;
    logic signed [ACC_W-1:0] fused_acc;

    t_calc lim_ext, lf_ext, rf_ext, f, fsum, fsm;

    assign ld4 = r_v3 && (!r_v4 || o_out.ready);
    assign ld3 = r_v2 && (!r_v3 || ld4);
    assign ld2 = r_v1 && (!r_v2 || ld3);
    assign i_in.ready = !r_v1 || ld2;
    assign ld1 = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_limit     <= SPEED_LIMIT_RST;
            r_cfg.accel_threshold <= ACCEL_THR_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_SPEED_LIMIT) begin
                r_cfg.speed_limit <= i_cfg_data;
            end else if (i_cfg_idx == CFG_ACCEL_THR) begin
                r_cfg.accel_threshold <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= ld1 || (r_v1 && !ld2);
            r_v2 <= ld2 || (r_v2 && !ld3);
            r_v3 <= ld3 || (r_v3 && !ld4);
            r_v4 <= ld4 || (r_v4 && !o_out.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r1_lcount <= i_in.left_count;
            r1_ldir   <= i_in.left_dir;
            r1_rcount <= i_in.right_count;
            r1_rdir   <= i_in.right_dir;
            r1_mode   <= i_in.accum_mode;
        end
        if (ld2) begin
            r2_mode <= r1_mode;
        end
        if (ld3) begin
            r3_lf    <= w_lf;
            r3_rf    <= w_rf;
            r3_lflag <= w_lflag;
            r3_rflag <= w_rflag;
            r3_mode  <= r2_mode;
        end
        if (ld4) begin
            r4_fused <= r_fused;
            r4_lf    <= r3_lf;
            r4_rf    <= r3_rf;
            r4_lflag <= r3_lflag;
            r4_rflag <= r3_rflag;
        end
    end

    esrf_wheel u_left (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (ld2),
        .i_count    (r1_lcount),
        .i_neg      (!r1_ldir),
        .i_cfg      (r_cfg),
        .o_filtered (w_lf),
        .o_flag     (w_lflag)
    );

    esrf_wheel u_right (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (ld2),
        .i_count    (r1_rcount),
        .i_neg      (r1_rdir),
        .i_cfg      (r_cfg),
        .o_filtered (w_rf),
        .o_flag     (w_rflag)
    );

    // fuse the wheels, clamping to the limit around a runaway wheel, then smooth
    always_comb begin
        lim_ext = zext_cfg(r_cfg.speed_limit);
        lf_ext  = sext_spd(w_lf);
        rf_ext  = sext_spd(w_rf);
        priority if (w_lflag != RUN_NONE && w_rflag != RUN_NONE) begin
            f = lim_ext;
        end else if (w_lflag != RUN_NONE) begin
            f = (rf_ext > lim_ext) ? lim_ext : rf_ext;
        end else if (w_rflag != RUN_NONE) begin
            f = (lf_ext > lim_ext) ? lim_ext : lf_ext;
        end else begin
            f = sdiv2(lf_ext + rf_ext);
        end
        fsum    = (f <<< 3) + f + sext_spd(r_fused);
        fsm     = sdiv10(fsum);
        n_fused = fsm[SPD_W-1:0];
    end

    assign fused_acc = $signed({{(ACC_W-SPD_W){r_fused[SPD_W-1]}}, r_fused});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fused <= '0;
            r_inner <= '0;
            r_outer <= '0;
            r_total <= '0;
        end else begin
            if (ld3) begin
                r_fused <= n_fused;
            end
            if (ld4) begin
                r_total <= r_total + fused_acc;
                if (r3_mode == MODE_INNER) begin
                    r_inner <= r_inner + fused_acc;
                end
                if (r3_mode == MODE_OUTER) begin
                    r_outer <= r_outer + fused_acc;
                end
            end
        end
    end

    assign o_out.valid          = r_v4;
    assign o_out.fused_speed    = r4_fused;
    assign o_out.left_filtered  = r4_lf;
    assign o_out.right_filtered = r4_rf;
    assign o_out.left_flag      = r4_lflag;
    assign o_out.right_flag     = r4_rflag;
    assign o_out.inner_distance = r_inner;
    assign o_out.outer_distance = r_outer;
    assign o_out.total_distance = r_total;

endmodule

[rtl/core/esrf_checker.sv]
// Port-level checks for the encoder speed runaway filter, bound to the top level.
module esrf_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_ready,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic signed [esrf_pkg::SPD_W-1:0] i_fused_speed,
    input logic [1:0]                       i_left_flag,
    input logic [1:0]                       i_right_flag,
    input logic signed [esrf_pkg::ACC_W-1:0] i_total_distance
);
    import esrf_pkg::*;

    logic signed [ACC_W-1:0] r_last_total;

    // track the total of the last beat taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_total <= '0;
        end else if (i_out_valid && i_out_ready) begin
            r_last_total <= i_total_distance;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_fused_speed)
            && $stable(i_total_distance))
        else $error("stalled output beat changed");

    a_total_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_total_distance ==
            r_last_total + $signed({{(ACC_W-SPD_W){i_fused_speed[SPD_W-1]}}, i_fused_speed}))
        else $error("total distance does not step by the fused speed");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input not ready with the output stage empty");

    a_flag_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_left_flag != 2'd3 && i_right_flag != 2'd3)
        else $error("runaway flag holds an unused code");

endmodule

bind encoder_speed_runaway_filter esrf_checker u_esrf_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_fused_speed    (o_out.fused_speed),
    .i_left_flag      (o_out.left_flag),
    .i_right_flag     (o_out.right_flag),
    .i_total_distance (o_out.total_distance)
);
